// ===== rtl/hpq_pkg.sv =====
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types, codes and defaults for the binary heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_WIDTH = 32;

  // entry count holds 0 .. CAPACITY
  function automatic int cnt_width(input int cap);
    return $clog2(cap + 1);
  endfunction

  // request action codes
  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LAST,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_DONE
  } state_t;

endpackage

// ===== rtl/hpq_if.sv =====
// ----------------------------------------------------------------------------
// hpq_if
// Request and response channels of the heap: valid/ready with payload.
// ----------------------------------------------------------------------------
interface hpq_req_if #(
  parameter int KEY_W = hpq_pkg::KEY_WIDTH
);
  logic             valid;
  logic             ready;
  logic             action;
  logic [KEY_W-1:0] key;

  modport source (output valid, action, key, input ready);
  modport sink   (input valid, action, key, output ready);
endinterface

interface hpq_rsp_if #(
  parameter int KEY_W = hpq_pkg::KEY_WIDTH,
  parameter int CNT_W = hpq_pkg::cnt_width(hpq_pkg::CAPACITY)
);
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [KEY_W-1:0] extracted;
  logic [KEY_W-1:0] top;
  logic [CNT_W-1:0] count;

  modport source (output valid, status, extracted, top, count, input ready);
  modport sink   (input valid, status, extracted, top, count, output ready);
endinterface

// ===== rtl/hpq_ram.sv =====
// ----------------------------------------------------------------------------
// hpq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hpq_ram #(
  parameter int WIDTH = hpq_pkg::KEY_WIDTH,
  parameter int DEPTH = hpq_pkg::CAPACITY
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/binary_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Array-based binary heap of keys with insert and extract-root requests.
// ----------------------------------------------------------------------------
// Each request beat yields one response beat carrying status, the extracted
// key, the new root and the entry count. The heap lives in a single RAM with
// one write and one registered read port; the root is mirrored in a register.
// An insert climbs one level per read and compare of the parent, moving the
// parent down into the hole; an extract descends one level per read of the
// left child, read of the right child and compare, moving a better child up,
// the RAM read port and the single shared comparator setting the pace. A full
// insert, an empty extract or an extract of the last entry go straight to the
// done state. A waiting response holds the sequencer in its last cycle.
// A new request is taken as soon as the sequencer is idle, even while the
// previous response still waits.
// min_first selects smallest-at-root (1) or largest-at-root (0) and should
// only be written while the queue is idle; stored entries are not reordered.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue #(
  parameter int CAPACITY  = hpq_pkg::CAPACITY,
  parameter int KEY_WIDTH = hpq_pkg::KEY_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_data,
  hpq_req_if.sink   req,
  hpq_rsp_if.source rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = hpq_pkg::cnt_width(CAPACITY);
  localparam int IW = AW + 1;

  hpq_pkg::state_t state, state_next;

  logic                 min_first;
  logic [CW-1:0]        count, count_next;
  logic [AW-1:0]        pos, pos_next;
  logic [KEY_WIDTH-1:0] hold_key, hold_key_next;
  logic [KEY_WIDTH-1:0] best_key, best_key_next;
  logic                 best_sel, best_sel_next;
  logic                 r_ok, r_ok_next;
  logic [KEY_WIDTH-1:0] top_key;
  hpq_pkg::status_t     status, status_next;
  logic [KEY_WIDTH-1:0] extracted, extracted_next;

  logic                 rsp_valid;
  logic                 rsp_load;
  hpq_pkg::status_t     rsp_status;
  logic [KEY_WIDTH-1:0] rsp_extracted;
  logic [KEY_WIDTH-1:0] rsp_top;
  logic [CW-1:0]        rsp_count;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [KEY_WIDTH-1:0] mem_rdata;

  logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
  logic                 cmp_better;

  logic [AW-1:0]        parent;
  logic [IW-1:0]        l_idx, r_idx, count_ext;

  hpq_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // tree index arithmetic
  assign parent    = AW'((pos - AW'(1)) >> 1);
  assign l_idx     = {pos, 1'b1};
  assign r_idx     = l_idx + IW'(1);
  assign count_ext = IW'(count);

  // the one shared comparator: a belongs nearer the root than b
  assign cmp_better = min_first ? (cmp_a < cmp_b) : (cmp_a > cmp_b);

  assign req.ready = (state == hpq_pkg::S_IDLE);

  always_comb begin
    state_next     = state;
    count_next     = count;
    pos_next       = pos;
    hold_key_next  = hold_key;
    best_key_next  = best_key;
    best_sel_next  = best_sel;
    r_ok_next      = r_ok;
    status_next    = status;
    extracted_next = extracted;
    mem_we         = 1'b0;
    mem_waddr      = pos;
    mem_wdata      = hold_key;
    mem_raddr      = pos;
    cmp_a          = mem_rdata;
    cmp_b          = hold_key;
    rsp_load       = 1'b0;

    case (state)
      hpq_pkg::S_IDLE: begin
        if (req.valid) begin
          status_next    = hpq_pkg::ST_OK;
          extracted_next = '0;
          if (req.action == hpq_pkg::ACT_INSERT) begin
            if (count == CW'(CAPACITY)) begin
              status_next = hpq_pkg::ST_FULL;
              state_next  = hpq_pkg::S_DONE;
            end else begin
              count_next    = count + CW'(1);
              pos_next      = count[AW-1:0];
              hold_key_next = req.key;
              state_next    = hpq_pkg::S_UP_RD;
            end
          end else begin
            if (count == '0) begin
              status_next = hpq_pkg::ST_EMPTY;
              state_next  = hpq_pkg::S_DONE;
            end else begin
              extracted_next = top_key;
              count_next     = count - CW'(1);
              if (count == CW'(1)) begin
                state_next = hpq_pkg::S_DONE;
              end else begin
                // fetch the last entry, it restarts at the root
                mem_raddr  = AW'(count - CW'(1));
                state_next = hpq_pkg::S_DN_LAST;
              end
            end
          end
        end
      end

      hpq_pkg::S_UP_RD: begin
        if (pos == '0) begin
          mem_we     = 1'b1;
          state_next = hpq_pkg::S_DONE;
        end else begin
          mem_raddr  = parent;
          state_next = hpq_pkg::S_UP_CMP;
        end
      end

      hpq_pkg::S_UP_CMP: begin
        cmp_a = hold_key;
        cmp_b = mem_rdata;
        mem_we = 1'b1;
        if (cmp_better) begin
          // parent drops into the hole
          mem_wdata  = mem_rdata;
          pos_next   = parent;
          state_next = hpq_pkg::S_UP_RD;
        end else begin
          state_next = hpq_pkg::S_DONE;
        end
      end

      hpq_pkg::S_DN_LAST: begin
        hold_key_next = mem_rdata;
        pos_next      = '0;
        state_next    = hpq_pkg::S_DN_L;
      end

      hpq_pkg::S_DN_L: begin
        if (l_idx < count_ext) begin
          mem_raddr  = l_idx[AW-1:0];
          state_next = hpq_pkg::S_DN_R;
        end else begin
          mem_we     = 1'b1;
          state_next = hpq_pkg::S_DONE;
        end
      end

      hpq_pkg::S_DN_R: begin
        // left child against the moving key
        best_sel_next = cmp_better;
        best_key_next = cmp_better ? mem_rdata : hold_key;
        r_ok_next     = (r_idx < count_ext);
        mem_raddr     = r_idx[AW-1:0];
        state_next    = hpq_pkg::S_DN_CMP;
      end

      hpq_pkg::S_DN_CMP: begin
        cmp_b  = best_key;
        mem_we = 1'b1;
        if (r_ok && cmp_better) begin
          mem_wdata  = mem_rdata;
          pos_next   = r_idx[AW-1:0];
          state_next = hpq_pkg::S_DN_L;
        end else if (best_sel) begin
          mem_wdata  = best_key;
          pos_next   = l_idx[AW-1:0];
          state_next = hpq_pkg::S_DN_L;
        end else begin
          state_next = hpq_pkg::S_DONE;
        end
      end

      hpq_pkg::S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_load   = 1'b1;
          state_next = hpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = hpq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hpq_pkg::S_IDLE;
      count     <= '0;
      min_first <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_we) begin
        min_first <= cfg_data;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos       <= pos_next;
    hold_key  <= hold_key_next;
    best_key  <= best_key_next;
    best_sel  <= best_sel_next;
    r_ok      <= r_ok_next;
    status    <= status_next;
    extracted <= extracted_next;
    // root mirror follows every write to slot zero
    if (mem_we && mem_waddr == '0) begin
      top_key <= mem_wdata;
    end
    if (rsp_load) begin
      rsp_status    <= status;
      rsp_extracted <= extracted;
      rsp_top       <= (count == '0) ? '0 : top_key;
      rsp_count     <= count;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.extracted = rsp_extracted;
  assign rsp.top       = rsp_top;
  assign rsp.count     = rsp_count;

endmodule
